// ===== hdl/rtzi_pkg.sv =====
// ----------------------------------------------------------------------------
// rtzi_pkg
// Shared types and default sizes for the vertical ray / triangle test.
// ----------------------------------------------------------------------------
package rtzi_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int NUM_IN_FIELDS   = 11;

    // Orientation of one edge pair: both bits low means the points coincide.
    typedef struct packed {
        logic pos;
        logic neg;
    } sign_t;

endpackage

// ===== hdl/ray_triangle_z_intersection.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_z_intersection
// Point-in-triangle test of a vertical ray with barycentric weights and
// interpolated depth, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bits first)                   | tuser
//  s_axis   | in        | query_x query_y v1_xyz v2_xyz v3_xyz     | -
//  m_axis   | out       | depth_z weight_a weight_b weight_c, pad  | hit
//
// One request enters every cycle unless the output stalls. The weights come
// from the three restoring dividers, which resolve one quotient bit per stage.
// Reset clears only the valid bits of the stages; the data needs no reset.
// A stalled output freezes the whole pipeline at once, so nothing is lost or
// repeated, and s_axis_tready follows the output register's state.
// ----------------------------------------------------------------------------
module ray_triangle_z_intersection #(
    parameter int COORD_BITS  = rtzi_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_BITS = rtzi_pkg::WEIGHT_BITS_DEF,
    localparam int IN_W  = ((rtzi_pkg::NUM_IN_FIELDS * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_RAW = COORD_BITS + 3 * (WEIGHT_BITS + 1),
    localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // query_x, query_y, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
    input  logic [IN_W-1:0] s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // depth_z, weight_a, weight_b, weight_c, zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    // hit
    output logic            m_axis_tuser
);

    localparam int CB   = COORD_BITS;
    localparam int WB   = WEIGHT_BITS;
    localparam int DW   = CB + 1;           // shifted coordinate
    localparam int PRW  = 2 * DW;           // one cross-product term
    localparam int ARW  = PRW + 1;          // signed area
    localparam int MW   = ARW - 1;          // area magnitude
    localparam int SW   = MW + 2;           // sum of three magnitudes
    localparam int QW   = WB + 1;           // weight
    localparam int NDIV = WB + 1;           // divider stages
    localparam int ZPW  = QW + 1 + CB;      // weight times z
    localparam int ACW  = ZPW + 2;          // sum of three such products

    logic adv;

    // Stage 1: shift the vertices to the query point.
    logic                 v1_reg;
    logic signed [DW-1:0] dx1_reg [3];
    logic signed [DW-1:0] dy1_reg [3];
    logic signed [CB-1:0] z1_reg  [3];

    // Stage 2: cross-product terms and coincidence tie-breaks.
    logic                  v2_reg;
    logic signed [PRW-1:0] pl_reg [3];
    logic signed [PRW-1:0] pr_reg [3];
    rtzi_pkg::sign_t       tie2_reg [3];
    logic signed [CB-1:0]  z2_reg [3];

    // Stage 3: signed areas.
    logic                  v3_reg;
    logic signed [ARW-1:0] area_reg [3];
    rtzi_pkg::sign_t       tie3_reg [3];
    logic signed [CB-1:0]  z3_reg [3];

    // Stage 4: orientation agreement and magnitudes.
    logic                 v4_reg;
    logic                 hit4_reg;
    logic [MW-1:0]        mag_reg [3];
    logic signed [CB-1:0] z4_reg [3];

    // Divider pipeline; index 0 is the stage that forms the area sum.
    logic                 dv_reg  [NDIV+1];
    logic                 dhit_reg[NDIV+1];
    logic [SW-1:0]        den_reg [NDIV+1];
    logic [SW-1:0]        rem_reg [NDIV+1][3];
    logic [QW-1:0]        q_reg   [NDIV+1][3];
    logic signed [CB-1:0] dz_reg  [NDIV+1][3];

    // Weight times z.
    logic                  v6_reg;
    logic                  hit6_reg;
    logic [QW-1:0]         w6_reg  [3];
    logic signed [ZPW-1:0] zp_reg  [3];

    // Output register.
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic signed [CB-1:0] out_depth_reg;
    logic [QW-1:0]        out_w_reg [3];

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- stage 1 ----------------
    logic signed [CB-1:0] in_f [rtzi_pkg::NUM_IN_FIELDS];

    always_comb
    begin
        for (int f = 0; f < rtzi_pkg::NUM_IN_FIELDS; f++)
        begin
            in_f[f] = s_axis_tdata[f*CB +: CB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dx1_reg[i] <= DW'(in_f[2 + 3*i]) - DW'(in_f[0]);
                dy1_reg[i] <= DW'(in_f[3 + 3*i]) - DW'(in_f[1]);
                z1_reg[i]  <= in_f[4 + 3*i];
            end
        end
    end

    // ---------------- stage 2 ----------------
    // Area i uses the vertex pair (p, q): (2,3), (3,1), (1,2).
    function automatic int pidx(input int i);
        int r;
        r = (i + 1) % 3;
        return r;
    endfunction

    function automatic int qidx(input int i);
        int r;
        r = (i + 2) % 3;
        return r;
    endfunction

    // Simulation of simplicity for a zero area: y order first, then x order.
    function automatic rtzi_pkg::sign_t tie_sign(input logic signed [DW-1:0] xp,
                                                 input logic signed [DW-1:0] yp,
                                                 input logic signed [DW-1:0] xq,
                                                 input logic signed [DW-1:0] yq);
        rtzi_pkg::sign_t s;
        s = '0;
        priority if (yq > yp) s.pos = 1'b1;
        else if (yq < yp)     s.neg = 1'b1;
        else if (xp > xq)     s.pos = 1'b1;
        else if (xp < xq)     s.neg = 1'b1;
        else                  s = '0;
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i]   <= PRW'(dy1_reg[pidx(i)]) * PRW'(dx1_reg[qidx(i)]);
                pr_reg[i]   <= PRW'(dx1_reg[pidx(i)]) * PRW'(dy1_reg[qidx(i)]);
                tie2_reg[i] <= tie_sign(dx1_reg[pidx(i)], dy1_reg[pidx(i)],
                                        dx1_reg[qidx(i)], dy1_reg[qidx(i)]);
                z2_reg[i]   <= z1_reg[i];
            end
        end
    end

    // ---------------- stage 3 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                area_reg[i] <= ARW'(pl_reg[i]) - ARW'(pr_reg[i]);
                tie3_reg[i] <= tie2_reg[i];
                z3_reg[i]   <= z2_reg[i];
            end
        end
    end

    // ---------------- stage 4 ----------------
    rtzi_pkg::sign_t sgn [3];
    logic            hit4_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (area_reg[i] == '0)
            begin
                sgn[i] = tie3_reg[i];
            end
            else
            begin
                sgn[i].neg = area_reg[i][ARW-1];
                sgn[i].pos = !area_reg[i][ARW-1];
            end
        end
        hit4_next = (sgn[0].pos || sgn[0].neg) && (sgn[1] == sgn[0]) && (sgn[2] == sgn[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit4_reg <= hit4_next;
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= area_reg[i][ARW-1] ? MW'(-area_reg[i]) : MW'(area_reg[i]);
                z4_reg[i]  <= z3_reg[i];
            end
        end
    end

    // ---------------- stage 5: area sum ----------------
    logic [SW-1:0] sum5;

    assign sum5 = SW'(mag_reg[0]) + SW'(mag_reg[1]) + SW'(mag_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dhit_reg[0] <= hit4_reg && (sum5 != '0);
            den_reg[0]  <= sum5;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= SW'(mag_reg[i]);
                q_reg[0][i]   <= '0;
                dz_reg[0][i]  <= z4_reg[i];
            end
        end
    end

    // ---------------- divider stages ----------------
    // Stage j resolves quotient bit WB+1-j; the first stage compares the
    // magnitude itself, as it never exceeds the sum.
    for (genvar j = 1; j <= NDIV; j++)
    begin : g_div
        logic [SW:0]   trial [3];
        logic [SW-1:0] rem_next [3];
        logic [QW-1:0] q_next [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (j == 1)
                begin
                    trial[i] = {1'b0, rem_reg[j-1][i]};
                end
                else
                begin
                    trial[i] = {rem_reg[j-1][i], 1'b0};
                end
                q_next[i] = {q_reg[j-1][i][QW-2:0], 1'b0};
                if (trial[i] >= {1'b0, den_reg[j-1]})
                begin
                    rem_next[i]  = SW'(trial[i] - {1'b0, den_reg[j-1]});
                    q_next[i][0] = 1'b1;
                end
                else
                begin
                    rem_next[i] = SW'(trial[i]);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dhit_reg[j] <= dhit_reg[j-1];
                den_reg[j]  <= den_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[j][i] <= rem_next[i];
                    q_reg[j][i]   <= q_next[i];
                    dz_reg[j][i]  <= dz_reg[j-1][i];
                end
            end
        end
    end

    // ---------------- stage 6: weight times z ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= dv_reg[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit6_reg <= dhit_reg[NDIV];
            for (int i = 0; i < 3; i++)
            begin
                w6_reg[i] <= q_reg[NDIV][i];
                zp_reg[i] <= $signed(ZPW'({1'b0, q_reg[NDIV][i]}))
                             * ZPW'(dz_reg[NDIV][i]);
            end
        end
    end

    // ---------------- stage 7: depth and output register ----------------
    logic signed [ACW-1:0] acc;
    logic signed [ACW-1:0] acc_sh;

    assign acc    = ACW'(zp_reg[0]) + ACW'(zp_reg[1]) + ACW'(zp_reg[2]);
    assign acc_sh = acc >>> WB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg   <= hit6_reg;
            out_depth_reg <= hit6_reg ? acc_sh[CB-1:0] : '0;
            for (int i = 0; i < 3; i++)
            begin
                out_w_reg[i] <= hit6_reg ? w6_reg[i] : '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = OUT_W'({out_w_reg[2], out_w_reg[1], out_w_reg[0], out_depth_reg});

    // ---------------- assertions ----------------
    logic [QW+1:0] w_total;

    assign w_total = (QW+2)'(out_w_reg[0]) + (QW+2)'(out_w_reg[1]) + (QW+2)'(out_w_reg[2]);

    // A miss carries no weights and no depth.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> (w_total == '0 && out_depth_reg == '0))
        else $error("miss result carries nonzero data");

    // Truncated weights of a hit add up to at most one and lose under three ulps.
    a_hit_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hit_reg) |->
        (w_total <= (QW+2)'(1 << WB) && w_total + (QW+2)'(2) >= (QW+2)'(1 << WB)))
        else $error("hit weights do not sum to one");

    // Each divider leaves a remainder below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[NDIV] && dhit_reg[NDIV]) |->
        (rem_reg[NDIV][0] < den_reg[NDIV] && rem_reg[NDIV][1] < den_reg[NDIV]
         && rem_reg[NDIV][2] < den_reg[NDIV]))
        else $error("divider remainder out of range");

    // A stalled pipeline keeps the output register valid and its result unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> (out_valid_reg && $stable(out_hit_reg) && $stable(out_depth_reg)))
        else $error("output changed during stall");

endmodule
